>>> rtl/seg_tri_pkg.sv
package seg_tri_pkg;

   typedef enum logic [1:0] {
      OUTCOME_NONE     = 2'd0,
      OUTCOME_PARALLEL = 2'd1,
      OUTCOME_MISS     = 2'd2,
      OUTCOME_HIT      = 2'd3
   } outcome_type;

   localparam logic [1:0] REG_VERTEX_0 = 2'd0;
   localparam logic [1:0] REG_VERTEX_1 = 2'd1;
   localparam logic [1:0] REG_VERTEX_2 = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

>>> rtl/segment_triangle_intersect.sv
// Tests a stream of line segments against one triangle held in three CSRs (byte addresses
// 0, 8, 16; x, y, z packed from bit 0 up). One segment is taken every cycle and each gives
// exactly one result. Four stages form the plane distances, FRACTION_BITS stages of a
// restoring divider form the segment fraction, and five stages form the crossing point
// and the edge tests. The whole pipeline holds while a result waits on rsp_tready. Plane
// and edge terms pass from the vertex registers through edge, normal-product, normal
// and projection registers after a write, so wait that long before sending segments.
module segment_triangle_intersect #(
   parameter int COORD_BITS    = 21,
   parameter int FRACTION_BITS = 24,
   localparam int IN_BITS  = 6 * COORD_BITS,
   localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS = 2 + 3 * COORD_BITS,
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // outcome, point_x, point_y, point_z
   output logic [OUT_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [63:0]      csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CB   = COORD_BITS;
   localparam int FB   = FRACTION_BITS;
   localparam int VW   = 3 * CB;
   localparam int DW   = CB + 1;
   localparam int NW   = 2 * DW + 1;
   localparam int PW   = NW + DW;
   localparam int SW   = PW + 2;
   localparam int DENW = SW + 1;
   localparam int KPW  = FB + 1 + DW;
   localparam int MW   = 2 * DW;

   function automatic logic signed [CB-1:0] coord_sel(input logic [VW-1:0] v,
                                                      input logic [1:0] ax);
      logic signed [CB-1:0] c;
      case (ax)
         seg_tri_pkg::AXIS_X: c = v[CB-1:0];
         seg_tri_pkg::AXIS_Y: c = v[2*CB-1:CB];
         seg_tri_pkg::AXIS_Z: c = v[3*CB-1:2*CB];
         default:             c = '0;
      endcase
      return c;
   endfunction

   // ---------------------------------------------------------------- CSRs
   logic [VW-1:0] vtx_ff [3];
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) vtx_ff[i] <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[4:3])
            seg_tri_pkg::REG_VERTEX_0: vtx_ff[0] <= csr_pwdata[VW-1:0];
            seg_tri_pkg::REG_VERTEX_1: vtx_ff[1] <= csr_pwdata[VW-1:0];
            seg_tri_pkg::REG_VERTEX_2: vtx_ff[2] <= csr_pwdata[VW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         seg_tri_pkg::REG_VERTEX_0: csr_prdata = 64'(vtx_ff[0]);
         seg_tri_pkg::REG_VERTEX_1: csr_prdata = 64'(vtx_ff[1]);
         seg_tri_pkg::REG_VERTEX_2: csr_prdata = 64'(vtx_ff[2]);
         default:                   csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------- triangle-derived terms
   logic signed [DW-1:0] e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [MW-1:0] nm1_ff [3], nm2_ff [3], nm1_in [3], nm2_in [3];
   logic signed [NW-1:0] n_ff [3], n_in [3];
   logic [1:0]           ua_ff, wa_ff, ua_in, wa_in;
   logic signed [CB-1:0] vu_ff [3], vw_ff [3], vu_in [3], vw_in [3];
   logic signed [DW-1:0] eu_ff [3], ew_ff [3], eu_in [3], ew_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         e1_in[a] = DW'(coord_sel(vtx_ff[1], 2'(a))) - DW'(coord_sel(vtx_ff[0], 2'(a)));
         e2_in[a] = DW'(coord_sel(vtx_ff[2], 2'(a))) - DW'(coord_sel(vtx_ff[0], 2'(a)));
         nm1_in[a] = e1_ff[(a+1)%3] * e2_ff[(a+2)%3];
         nm2_in[a] = e2_ff[(a+1)%3] * e1_ff[(a+2)%3];
         n_in[a]   = NW'(nm1_ff[a]) - NW'(nm2_ff[a]);
      end
      // projection plane picked by the first nonzero normal component
      if (n_ff[0] != '0) begin
         ua_in = seg_tri_pkg::AXIS_Y;
         wa_in = seg_tri_pkg::AXIS_Z;
      end else if (n_ff[1] != '0) begin
         ua_in = seg_tri_pkg::AXIS_Z;
         wa_in = seg_tri_pkg::AXIS_X;
      end else begin
         ua_in = seg_tri_pkg::AXIS_X;
         wa_in = seg_tri_pkg::AXIS_Y;
      end
      for (int i = 0; i < 3; i++) begin
         vu_in[i] = coord_sel(vtx_ff[i], ua_in);
         vw_in[i] = coord_sel(vtx_ff[i], wa_in);
         eu_in[i] = DW'(coord_sel(vtx_ff[(i+1)%3], ua_in)) - DW'(vu_in[i]);
         ew_in[i] = DW'(coord_sel(vtx_ff[(i+1)%3], wa_in)) - DW'(vw_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ua_ff <= seg_tri_pkg::AXIS_X;
         wa_ff <= seg_tri_pkg::AXIS_Y;
         for (int a = 0; a < 3; a++) begin
            e1_ff[a] <= '0;
            e2_ff[a] <= '0;
            nm1_ff[a] <= '0;
            nm2_ff[a] <= '0;
            n_ff[a] <= '0;
            vu_ff[a] <= '0;
            vw_ff[a] <= '0;
            eu_ff[a] <= '0;
            ew_ff[a] <= '0;
         end
      end else begin
         ua_ff <= ua_in;
         wa_ff <= wa_in;
         for (int a = 0; a < 3; a++) begin
            e1_ff[a] <= e1_in[a];
            e2_ff[a] <= e2_in[a];
            nm1_ff[a] <= nm1_in[a];
            nm2_ff[a] <= nm2_in[a];
            n_ff[a] <= n_in[a];
            vu_ff[a] <= vu_in[a];
            vw_ff[a] <= vw_in[a];
            eu_ff[a] <= eu_in[a];
            ew_ff[a] <= ew_in[a];
         end
      end
   end

   // -------------------------------------------------------------- datapath
   logic advance;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: endpoints relative to v0
   logic                 s1_valid_ff;
   logic signed [CB-1:0] s1_s_ff [3], s1_t_ff [3], s1_s_in [3], s1_t_in [3];
   logic signed [DW-1:0] s1_ds_ff [3], s1_dt_ff [3], s1_ds_in [3], s1_dt_in [3];
   // stage 2: plane products
   logic                 s2_valid_ff;
   logic signed [CB-1:0] s2_s_ff [3], s2_t_ff [3];
   logic signed [PW-1:0] s2_mp_ff [3], s2_mq_ff [3], s2_mp_in [3], s2_mq_in [3];
   // stage 3: plane distances
   logic                 s3_valid_ff;
   logic signed [CB-1:0] s3_s_ff [3], s3_t_ff [3];
   logic signed [SW-1:0] s3_ds_ff, s3_dt_ff, s3_ds_in, s3_dt_in;
   // stage 4: divider operands
   logic                 s4_valid_ff, s4_cross_ff, s4_par_ff, s4_cross_in, s4_par_in;
   logic signed [CB-1:0] s4_s_ff [3];
   logic signed [DW-1:0] s4_dif_ff [3], s4_dif_in [3];
   logic [DENW-1:0]      s4_rem_ff, s4_den_ff, s4_rem_in, s4_den_in;
   logic signed [SW:0]   s3_den_sgn;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s1_s_in[a]  = req_tdata[a*CB +: CB];
         s1_t_in[a]  = req_tdata[(3+a)*CB +: CB];
         s1_ds_in[a] = DW'(s1_s_in[a]) - DW'(coord_sel(vtx_ff[0], 2'(a)));
         s1_dt_in[a] = DW'(s1_t_in[a]) - DW'(coord_sel(vtx_ff[0], 2'(a)));
         s2_mp_in[a] = PW'(n_ff[a]) * PW'(s1_ds_ff[a]);
         s2_mq_in[a] = PW'(n_ff[a]) * PW'(s1_dt_ff[a]);
         s4_dif_in[a] = DW'(s3_t_ff[a]) - DW'(s3_s_ff[a]);
      end
      s3_ds_in = SW'(s2_mp_ff[0]) + SW'(s2_mp_ff[1]) + SW'(s2_mp_ff[2]);
      s3_dt_in = SW'(s2_mq_ff[0]) + SW'(s2_mq_ff[1]) + SW'(s2_mq_ff[2]);
      // the crossing denominator n.(T-S) equals dt - ds
      s3_den_sgn  = (SW+1)'(s3_dt_ff) - (SW+1)'(s3_ds_ff);
      s4_cross_in = (s3_ds_ff != '0) && (s3_dt_ff != '0) &&
                    (s3_ds_ff[SW-1] != s3_dt_ff[SW-1]);
      s4_par_in   = (s3_den_sgn == '0);
      s4_rem_in   = s3_ds_ff[SW-1] ? DENW'(-(SW+1)'(s3_ds_ff)) : DENW'(s3_ds_ff);
      s4_den_in   = s3_den_sgn[SW] ? DENW'(-s3_den_sgn) : DENW'(s3_den_sgn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            s1_s_ff[a]  <= s1_s_in[a];
            s1_t_ff[a]  <= s1_t_in[a];
            s1_ds_ff[a] <= s1_ds_in[a];
            s1_dt_ff[a] <= s1_dt_in[a];
            s2_s_ff[a]  <= s1_s_ff[a];
            s2_t_ff[a]  <= s1_t_ff[a];
            s2_mp_ff[a] <= s2_mp_in[a];
            s2_mq_ff[a] <= s2_mq_in[a];
            s3_s_ff[a]  <= s2_s_ff[a];
            s3_t_ff[a]  <= s2_t_ff[a];
            s4_s_ff[a]  <= s3_s_ff[a];
            s4_dif_ff[a] <= s4_dif_in[a];
         end
         s3_ds_ff    <= s3_ds_in;
         s3_dt_ff    <= s3_dt_in;
         s4_cross_ff <= s4_cross_in;
         s4_par_ff   <= s4_par_in;
         s4_rem_ff   <= s4_rem_in;
         s4_den_ff   <= s4_den_in;
      end
   end

   // restoring divider: one quotient bit per stage, |ds| < |den| so FB bits suffice
   logic                 dv_valid_ff [FB];
   logic                 dv_cross_ff [FB], dv_par_ff [FB];
   logic [DENW-1:0]      dv_rem_ff [FB], dv_den_ff [FB], dv_rem_in [FB];
   logic [FB-1:0]        dv_q_ff [FB], dv_q_in [FB];
   logic signed [CB-1:0] dv_s_ff [FB][3];
   logic signed [DW-1:0] dv_dif_ff [FB][3];

   always_comb begin
      logic [DENW:0] rem2;
      logic [DENW:0] diff;
      logic [DENW-1:0] rem_prev, den_prev;
      logic [FB-1:0] q_prev;
      for (int i = 0; i < FB; i++) begin
         rem_prev = (i == 0) ? s4_rem_ff : dv_rem_ff[(i == 0) ? 0 : i-1];
         den_prev = (i == 0) ? s4_den_ff : dv_den_ff[(i == 0) ? 0 : i-1];
         q_prev   = (i == 0) ? '0 : dv_q_ff[(i == 0) ? 0 : i-1];
         rem2 = {rem_prev, 1'b0};
         diff = rem2 - {1'b0, den_prev};
         if (!diff[DENW]) begin
            dv_rem_in[i] = diff[DENW-1:0];
            dv_q_in[i]   = {q_prev[FB-2:0], 1'b1};
         end else begin
            dv_rem_in[i] = rem2[DENW-1:0];
            dv_q_in[i]   = {q_prev[FB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FB; i++) dv_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < FB; i++) dv_valid_ff[i] <= dv_valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < FB; i++) begin
            dv_rem_ff[i] <= dv_rem_in[i];
            dv_q_ff[i]   <= dv_q_in[i];
         end
         dv_den_ff[0]   <= s4_den_ff;
         dv_cross_ff[0] <= s4_cross_ff;
         dv_par_ff[0]   <= s4_par_ff;
         for (int a = 0; a < 3; a++) begin
            dv_s_ff[0][a]   <= s4_s_ff[a];
            dv_dif_ff[0][a] <= s4_dif_ff[a];
         end
         for (int i = 1; i < FB; i++) begin
            dv_den_ff[i]   <= dv_den_ff[i-1];
            dv_cross_ff[i] <= dv_cross_ff[i-1];
            dv_par_ff[i]   <= dv_par_ff[i-1];
            for (int a = 0; a < 3; a++) begin
               dv_s_ff[i][a]   <= dv_s_ff[i-1][a];
               dv_dif_ff[i][a] <= dv_dif_ff[i-1][a];
            end
         end
      end
   end

   // P1: fraction times segment direction
   logic                  p1_valid_ff, p1_cross_ff, p1_par_ff;
   logic signed [CB-1:0]  p1_s_ff [3];
   logic signed [KPW-1:0] p1_prod_ff [3], p1_prod_in [3];
   // P2: rounded crossing point
   logic                  p2_valid_ff, p2_cross_ff, p2_par_ff;
   logic signed [CB-1:0]  p2_p_ff [3], p2_p_in [3];

   always_comb begin
      logic [KPW-1:0] mag;
      logic [KPW:0]   rs;
      logic signed [DW+2:0] sx, rr, pv;
      for (int a = 0; a < 3; a++) begin
         p1_prod_in[a] = signed'(KPW'({1'b0, dv_q_ff[FB-1]})) * KPW'(dv_dif_ff[FB-1][a]);
         mag = p1_prod_ff[a][KPW-1] ? KPW'(-p1_prod_ff[a]) : KPW'(p1_prod_ff[a]);
         // round half away from zero on the magnitude
         rs  = {1'b0, mag} + ((KPW+1)'(1) << (FB - 1));
         sx  = (DW+3)'(p1_s_ff[a]);
         rr  = signed'((DW+3)'(rs[KPW:FB]));
         pv  = p1_prod_ff[a][KPW-1] ? sx - rr : sx + rr;
         p2_p_in[a] = pv[CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= dv_valid_ff[FB-1];
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_cross_ff <= dv_cross_ff[FB-1];
         p1_par_ff   <= dv_par_ff[FB-1];
         p2_cross_ff <= p1_cross_ff;
         p2_par_ff   <= p1_par_ff;
         for (int a = 0; a < 3; a++) begin
            p1_s_ff[a]    <= dv_s_ff[FB-1][a];
            p1_prod_ff[a] <= p1_prod_in[a];
            p2_p_ff[a]    <= p2_p_in[a];
         end
      end
   end

   // E1: projected point relative to each vertex, E2: edge cross products
   logic                 e1s_valid_ff, e1s_cross_ff, e1s_par_ff;
   logic signed [CB-1:0] e1s_p_ff [3];
   logic signed [DW-1:0] du_ff [3], dw_ff [3], du_in [3], dw_in [3];
   logic                 e2s_valid_ff, e2s_cross_ff, e2s_par_ff;
   logic signed [CB-1:0] e2s_p_ff [3];
   logic signed [MW-1:0] m1_ff [3], m2_ff [3], m1_in [3], m2_in [3];

   always_comb begin
      logic signed [CB-1:0] pu, pw;
      pu = coord_sel({p2_p_ff[2], p2_p_ff[1], p2_p_ff[0]}, ua_ff);
      pw = coord_sel({p2_p_ff[2], p2_p_ff[1], p2_p_ff[0]}, wa_ff);
      for (int i = 0; i < 3; i++) begin
         du_in[i] = DW'(pu) - DW'(vu_ff[i]);
         dw_in[i] = DW'(pw) - DW'(vw_ff[i]);
         m1_in[i] = MW'(du_ff[i]) * MW'(ew_ff[i]);
         m2_in[i] = MW'(dw_ff[i]) * MW'(eu_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1s_valid_ff <= 1'b0;
         e2s_valid_ff <= 1'b0;
      end else if (advance) begin
         e1s_valid_ff <= p2_valid_ff;
         e2s_valid_ff <= e1s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1s_cross_ff <= p2_cross_ff;
         e1s_par_ff   <= p2_par_ff;
         e2s_cross_ff <= e1s_cross_ff;
         e2s_par_ff   <= e1s_par_ff;
         for (int i = 0; i < 3; i++) begin
            e1s_p_ff[i] <= p2_p_ff[i];
            e2s_p_ff[i] <= e1s_p_ff[i];
            du_ff[i]    <= du_in[i];
            dw_ff[i]    <= dw_in[i];
            m1_ff[i]    <= m1_in[i];
            m2_ff[i]    <= m2_in[i];
         end
      end
   end

   // output register
   logic                    rsp_valid_ff;
   seg_tri_pkg::outcome_type rsp_outcome_ff, rsp_outcome_in;
   logic signed [CB-1:0]    rsp_p_ff [3], rsp_p_in [3];

   always_comb begin
      logic signed [MW:0] cp [3];
      logic all_neg, all_pos;
      for (int i = 0; i < 3; i++) cp[i] = (MW+1)'(m1_ff[i]) - (MW+1)'(m2_ff[i]);
      all_neg = cp[0][MW] && cp[1][MW] && cp[2][MW];
      all_pos = (cp[0] > 0) && (cp[1] > 0) && (cp[2] > 0);
      if (!e2s_cross_ff) begin
         rsp_outcome_in = seg_tri_pkg::OUTCOME_NONE;
      end else if (e2s_par_ff) begin
         rsp_outcome_in = seg_tri_pkg::OUTCOME_PARALLEL;
      end else if (all_neg || all_pos) begin
         rsp_outcome_in = seg_tri_pkg::OUTCOME_HIT;
      end else begin
         rsp_outcome_in = seg_tri_pkg::OUTCOME_MISS;
      end
      for (int a = 0; a < 3; a++) begin
         rsp_p_in[a] = (e2s_cross_ff && !e2s_par_ff) ? e2s_p_ff[a] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= e2s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_outcome_ff <= rsp_outcome_in;
         for (int a = 0; a < 3; a++) rsp_p_ff[a] <= rsp_p_in[a];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_p_ff[2], rsp_p_ff[1], rsp_p_ff[0], rsp_outcome_ff});

endmodule
